// ===== src/eabl_pkg.sv =====
`default_nettype none

package eabl_pkg;

    // Position of the data byte inside the raw link word.
    localparam int DATA_SHIFT = 23;

    localparam int OP_W    = 2;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 10;
    localparam int EVENT_W = 3;

    // Operation codes carried on the input side.
    localparam logic [OP_W-1:0] OP_LINK_WORD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND       = 2'd1;
    localparam logic [OP_W-1:0] OP_INITIATE   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESPOND    = 2'd3;

    // Event codes reported with every result word.
    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RX        = 3'd1;
    localparam logic [EVENT_W-1:0] EV_SEND_ACK  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_STRAY     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_HS_DONE   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_BUSY      = 3'd5;

    localparam logic [BYTE_W-1:0] HANDSHAKE_REPLY = 8'hDF;

    // One input word after unpacking.
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] link_word;
        logic [BYTE_W-1:0] send_data;
    } item_t;

    // One result word before packing.
    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rx_valid;
        logic [FRAME_W-1:0] tx_frame;
        logic               tx_valid;
    } result_t;

    // Handshake sequence 02 04 08 00.
    function automatic logic [BYTE_W-1:0] hs_seq(input logic [1:0] idx);
        logic [BYTE_W-1:0] val;
        case (idx)
            2'd0:    val = 8'h02;
            2'd1:    val = 8'h04;
            2'd2:    val = 8'h08;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Line frame: start marker in bit 9, inverted byte in bits 8..1.
    function automatic logic [FRAME_W-1:0] frame_of(input logic [BYTE_W-1:0] b);
        return {1'b1, ~b, 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== src/eabl_in_reg.sv =====
`default_nettype none

module eabl_in_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [39:0]          s_tdata,   // link_word [31:0], send_data [39:32]
    input  wire logic [1:0]           s_tuser,   // operation [1:0]
    input  wire logic                 take,
    output logic                      item_valid,
    output eabl_pkg::item_t           item
);
    import eabl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register takes a new word when empty or when its word moves on.
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.operation <= s_tuser;
            item_reg.link_word <= s_tdata[WORD_W-1:0];
            item_reg.send_data <= s_tdata[WORD_W+BYTE_W-1:WORD_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== src/eabl_step.sv =====
`default_nettype none

module eabl_step (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire eabl_pkg::item_t      item,
    output eabl_pkg::result_t         res
);
    import eabl_pkg::*;

    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_SEND_WAIT  = 3'd1;
    localparam logic [2:0] MODE_INIT_SEND  = 3'd2;
    localparam logic [2:0] MODE_INIT_WAIT  = 3'd3;
    localparam logic [2:0] MODE_RESP_MATCH = 3'd4;
    localparam logic [2:0] MODE_RESP_REPLY = 3'd5;
    localparam logic [2:0] MODE_RESP_ECHO  = 3'd6;
    localparam logic [2:0] MODE_UNUSED     = 3'd7;

    logic [2:0]        mode_reg;
    logic [2:0]        mode_next;
    logic [BYTE_W-1:0] pending_reg;
    logic [BYTE_W-1:0] pending_next;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic [2:0]        cur_mode;
    logic [BYTE_W-1:0] rx_b;

    // Received byte: inverted link word, shifted down.
    assign rx_b = ~item.link_word[DATA_SHIFT+BYTE_W-1:DATA_SHIFT];

    // The unused mode code behaves as idle.
    assign cur_mode = (mode_reg == MODE_UNUSED) ? MODE_IDLE : mode_reg;

    // Next state and result for the word at hand.
    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        idx_next     = idx_reg;
        res          = '0;
        if (cur_mode == MODE_RESP_REPLY)
        begin
            pending_next = HANDSHAKE_REPLY;
            res.tx_valid = 1'b1;
            res.tx_frame = frame_of(HANDSHAKE_REPLY);
            mode_next    = MODE_RESP_ECHO;
        end
        else if (item.operation == OP_LINK_WORD)
        begin
            case (cur_mode)
                MODE_SEND_WAIT, MODE_RESP_ECHO:
                begin
                    if (rx_b == pending_reg)
                    begin
                        res.event_res = (cur_mode == MODE_SEND_WAIT) ? EV_SEND_ACK
                                                                     : EV_HS_DONE;
                        mode_next     = MODE_IDLE;
                    end
                    else
                    begin
                        res.event_res = EV_STRAY;
                    end
                end
                MODE_INIT_SEND:
                begin
                    if (rx_b == pending_reg)
                    begin
                        res.event_res = EV_SEND_ACK;
                        if (idx_reg == 2'd3)
                        begin
                            mode_next = MODE_INIT_WAIT;
                        end
                        else
                        begin
                            idx_next     = idx_reg + 2'd1;
                            pending_next = hs_seq(idx_reg + 2'd1);
                            res.tx_valid = 1'b1;
                            res.tx_frame = frame_of(hs_seq(idx_reg + 2'd1));
                        end
                    end
                    else
                    begin
                        res.event_res = EV_STRAY;
                    end
                end
                MODE_INIT_WAIT:
                begin
                    res.tx_valid = 1'b1;
                    res.tx_frame = frame_of(rx_b);
                    if (rx_b == HANDSHAKE_REPLY)
                    begin
                        res.event_res = EV_HS_DONE;
                        mode_next     = MODE_IDLE;
                    end
                end
                MODE_RESP_MATCH:
                begin
                    res.tx_valid = 1'b1;
                    res.tx_frame = frame_of(rx_b);
                    if (rx_b == hs_seq(idx_reg))
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            idx_next  = 2'd0;
                            mode_next = MODE_RESP_REPLY;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        idx_next = 2'd0;
                    end
                end
                default:
                begin
                    res.tx_valid  = 1'b1;
                    res.tx_frame  = frame_of(rx_b);
                    res.rx_valid  = 1'b1;
                    res.rx_byte   = rx_b;
                    res.event_res = EV_RX;
                end
            endcase
        end
        else if (cur_mode != MODE_IDLE)
        begin
            res.event_res = EV_BUSY;
        end
        else if (item.operation == OP_SEND)
        begin
            pending_next = item.send_data;
            res.tx_valid = 1'b1;
            res.tx_frame = frame_of(item.send_data);
            mode_next    = MODE_SEND_WAIT;
        end
        else if (item.operation == OP_INITIATE)
        begin
            idx_next     = 2'd0;
            pending_next = hs_seq(2'd0);
            res.tx_valid = 1'b1;
            res.tx_frame = frame_of(hs_seq(2'd0));
            mode_next    = MODE_INIT_SEND;
        end
        else
        begin
            idx_next  = 2'd0;
            mode_next = MODE_RESP_MATCH;
        end
    end

    // State advances only when the word moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pending_reg <= '0;
            idx_reg     <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            idx_reg     <= idx_next;
        end
    end

    // A pending reply always leaves on the next word.
    a_reply_then_echo: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_reg == MODE_RESP_REPLY |=> mode_reg == MODE_RESP_ECHO)
        else $error("reply pending did not move to echo wait");

    // No frame bits without a frame.
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !res.tx_valid |-> res.tx_frame == '0)
        else $error("frame bits set without a frame");

    // Delivery to the host only with the byte received event.
    a_rx_event: assert property (@(posedge clk) disable iff (!rst_n)
        res.rx_valid |-> res.event_res == EV_RX && res.tx_valid)
        else $error("delivered byte without echo or receive event");

endmodule

`default_nettype wire

// ===== src/eabl_out_reg.sv =====
`default_nettype none

module eabl_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    output logic                      load_ready,
    input  wire logic                 load,
    input  wire eabl_pkg::result_t    res,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // tx_frame [9:0], rx_byte [17:10], zero fill
    output logic [4:0]                m_tuser    // tx_valid [0], rx_valid [1], event_res [4:2]
);
    import eabl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result fits when the register is empty or is being drained.
    assign load_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            res_reg <= res;
        end
    end

    // Pack the result word onto the bus.
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.rx_byte, res_reg.tx_frame};
    assign m_tuser  = {res_reg.event_res, res_reg.rx_valid, res_reg.tx_valid};

endmodule

`default_nettype wire

// ===== src/echo_ack_byte_link_endpoint_top.sv =====
`default_nettype none

// Echo-acknowledged byte link endpoint. Every input word (a received link
// word, a send request, or a handshake start, selected by s_tuser) gives
// exactly one result word with the frame to transmit, the byte delivered to
// the host and an event code. A word passes an input register, one step of
// decode and mode update, and an output register, from which its result
// word is offered on the output; one word is taken every cycle while the
// output side keeps up. The mode, pending byte and sequence position are
// updated as a word moves into the output register. Requests made while a
// send or handshake is in progress are answered with the busy event, but
// a word at the reply step of a responder sends the reply instead.
module echo_ack_byte_link_endpoint_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // link_word [31:0], send_data [39:32]
    input  wire logic [1:0]  s_tuser,   // operation [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // tx_frame [9:0], rx_byte [17:10], zero fill
    output logic [4:0]       m_tuser    // tx_valid [0], rx_valid [1], event_res [4:2]
);
    import eabl_pkg::*;

    item_t   item;
    result_t res;
    logic    item_valid;
    logic    load_ready;
    logic    fire;

    // A word moves on when it is held and the result register has room.
    assign fire = item_valid && load_ready;

    eabl_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    eabl_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res)
    );

    eabl_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_ready (load_ready),
        .load       (item_valid),
        .res        (res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== dv/link_endpoint_checker.sv =====
`default_nettype none

// Watches both stream channels of the byte link endpoint. Every accepted input
// word is run through a local model of the endpoint, and the result it should
// give is queued. Every accepted result word is compared with the oldest entry.
module link_endpoint_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // link_word [31:0], send_data [39:32]
    input  wire logic [1:0]  s_tuser,   // operation [1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // tx_frame [9:0], rx_byte [17:10], zero fill
    input  wire logic [4:0]  m_tuser,   // tx_valid [0], rx_valid [1], event_res [4:2]
    output int               n_expected,
    output int               n_fail
);
    import eabl_pkg::*;

    // Handshake sequence 02 04 08 00, first byte in the low bits.
    localparam logic [31:0] HS_SEQUENCE = 32'h0008_0402;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_SEND_WAIT  = 3'd1,
        MODE_INIT_SEND  = 3'd2,
        MODE_INIT_WAIT  = 3'd3,
        MODE_RESP_MATCH = 3'd4,
        MODE_RESP_REPLY = 3'd5,
        MODE_RESP_ECHO  = 3'd6
    } link_mode_t;

    link_mode_t  link_mode;
    logic [7:0]  awaited_echo;
    logic [1:0]  seq_pos;
    result_t     awaited_results[$];
    int          errors = 0;

    function automatic logic [7:0] seq_byte(input logic [1:0] pos);
        return HS_SEQUENCE[pos*8 +: 8];
    endfunction

    // Start marker in bit 9 over the inverted byte in bits 8..1.
    function automatic logic [FRAME_W-1:0] line_frame(input logic [7:0] b);
        return 10'h200 | (10'(~b) << 1);
    endfunction

    // Advances the local endpoint state by one input word and returns the
    // result word it must produce.
    function automatic result_t next_result(input logic [1:0] op,
                                            input logic [31:0] word,
                                            input logic [7:0] sdata);
        result_t    r;
        logic [7:0] rx;
        r = '0;
        rx = 8'((~word) >> DATA_SHIFT);
        if (link_mode == MODE_RESP_REPLY)
        begin
            // The reply leaves now, whatever the word carries.
            awaited_echo = HANDSHAKE_REPLY;
            r.tx_valid = 1'b1;
            r.tx_frame = line_frame(HANDSHAKE_REPLY);
            link_mode = MODE_RESP_ECHO;
        end
        else if (op == OP_LINK_WORD)
        begin
            case (link_mode)
                MODE_SEND_WAIT, MODE_RESP_ECHO:
                begin
                    if (rx == awaited_echo)
                    begin
                        r.event_res = (link_mode == MODE_SEND_WAIT) ? EV_SEND_ACK : EV_HS_DONE;
                        link_mode = MODE_IDLE;
                    end
                    else
                    begin
                        r.event_res = EV_STRAY;
                    end
                end
                MODE_INIT_SEND:
                begin
                    if (rx == awaited_echo)
                    begin
                        r.event_res = EV_SEND_ACK;
                        if (seq_pos == 2'd3)
                        begin
                            link_mode = MODE_INIT_WAIT;
                        end
                        else
                        begin
                            seq_pos = seq_pos + 2'd1;
                            awaited_echo = seq_byte(seq_pos);
                            r.tx_valid = 1'b1;
                            r.tx_frame = line_frame(awaited_echo);
                        end
                    end
                    else
                    begin
                        r.event_res = EV_STRAY;
                    end
                end
                MODE_INIT_WAIT:
                begin
                    r.tx_valid = 1'b1;
                    r.tx_frame = line_frame(rx);
                    if (rx == HANDSHAKE_REPLY)
                    begin
                        r.event_res = EV_HS_DONE;
                        link_mode = MODE_IDLE;
                    end
                end
                MODE_RESP_MATCH:
                begin
                    r.tx_valid = 1'b1;
                    r.tx_frame = line_frame(rx);
                    if (rx == seq_byte(seq_pos))
                    begin
                        if (seq_pos == 2'd3)
                        begin
                            seq_pos = 2'd0;
                            link_mode = MODE_RESP_REPLY;
                        end
                        else
                        begin
                            seq_pos = seq_pos + 2'd1;
                        end
                    end
                    else
                    begin
                        // A mismatch starts over without comparing this byte again.
                        seq_pos = 2'd0;
                    end
                end
                default:
                begin
                    r.tx_valid = 1'b1;
                    r.tx_frame = line_frame(rx);
                    r.rx_valid = 1'b1;
                    r.rx_byte = rx;
                    r.event_res = EV_RX;
                end
            endcase
        end
        else if (link_mode != MODE_IDLE)
        begin
            r.event_res = EV_BUSY;
        end
        else if (op == OP_SEND)
        begin
            awaited_echo = sdata;
            r.tx_valid = 1'b1;
            r.tx_frame = line_frame(sdata);
            link_mode = MODE_SEND_WAIT;
        end
        else if (op == OP_INITIATE)
        begin
            seq_pos = 2'd0;
            awaited_echo = seq_byte(2'd0);
            r.tx_valid = 1'b1;
            r.tx_frame = line_frame(awaited_echo);
            link_mode = MODE_INIT_SEND;
        end
        else
        begin
            seq_pos = 2'd0;
            link_mode = MODE_RESP_MATCH;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Compare the result word first: it always belongs to an older input word.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            link_mode = MODE_IDLE;
            awaited_echo = 8'h00;
            seq_pos = 2'd0;
            awaited_results.delete();
            n_expected <= 0;
            n_fail <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("tx_valid", want.tx_valid, m_tuser[0]);
                    check_field("tx_frame", want.tx_frame, m_tdata[9:0]);
                    check_field("rx_valid", want.rx_valid, m_tuser[1]);
                    check_field("rx_byte", want.rx_byte, m_tdata[17:10]);
                    check_field("event_res", want.event_res, m_tuser[4:2]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(next_result(s_tuser, s_tdata[31:0], s_tdata[39:32]));
            end
            n_expected <= awaited_results.size();
            n_fail <= errors;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

// Drives the byte link endpoint with directed and random words, paces the
// result side, and gives the verdict from the checker's failure count.
module tb;
    import eabl_pkg::*;

    localparam logic [31:0] HS_SEQUENCE  = 32'h0008_0402;
    localparam int          ITEM_TARGET  = 1150;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          LIMIT_CYCLES = 200_000;
    localparam int          DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;
    int          n_expected;
    int          n_fail;
    int          n_items = 0;
    int          cycle_count = 0;
    logic        steady = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_served = 1'b0;

    echo_ack_byte_link_endpoint_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    link_endpoint_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .n_expected (n_expected),
        .n_fail     (n_fail)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, one long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever begin
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else begin
                m_tready <= steady || ($urandom_range(99) >= 35);
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] seq_byte(input int pos);
        return HS_SEQUENCE[pos*8 +: 8];
    endfunction

    // A raw link word that decodes to the given byte; the other bits are random.
    function automatic logic [31:0] word_for(input logic [7:0] b);
        logic [31:0] w;
        w = $urandom();
        w[30:23] = ~b;
        return w;
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] b);
        logic [7:0] x;
        x = 8'($urandom_range(255));
        while (x == b) x = 8'($urandom_range(255));
        return x;
    endfunction

    // Offer one word and return at the edge that accepts it.
    task automatic offer(input logic [1:0] op, input logic [31:0] word,
                         input logic [7:0] data);
        while (!steady && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {data, word};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_items++;
    endtask

    task automatic link(input logic [7:0] b);
        offer(OP_LINK_WORD, word_for(b), 8'($urandom_range(255)));
    endtask

    // Either a request that the busy endpoint must reject or an unrelated byte.
    task automatic busy_or_stray(input logic [7:0] avoid);
        logic [1:0] op;
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(2))
                0:       op = OP_SEND;
                1:       op = OP_INITIATE;
                default: op = OP_RESPOND;
            endcase
            offer(op, $urandom(), 8'($urandom_range(255)));
        end
        else begin
            link(other_than(avoid));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (n_expected != 0);
    endtask

    task automatic run_send(input logic [7:0] d);
        offer(OP_SEND, $urandom(), d);
        repeat ($urandom_range(2)) busy_or_stray(d);
        link(d);
    endtask

    task automatic run_initiator();
        offer(OP_INITIATE, $urandom(), 8'($urandom_range(255)));
        for (int k = 0; k < 4; k++) begin
            repeat ($urandom_range(1)) busy_or_stray(seq_byte(k));
            link(seq_byte(k));
        end
        repeat ($urandom_range(2)) busy_or_stray(HANDSHAKE_REPLY);
        link(HANDSHAKE_REPLY);
    endtask

    task automatic run_responder();
        int cut;
        offer(OP_RESPOND, $urandom(), 8'($urandom_range(255)));
        // Sometimes a partial sequence broken by a wrong byte comes first.
        if ($urandom_range(1) == 0) begin
            cut = $urandom_range(3);
            for (int k = 0; k < cut; k++) link(seq_byte(k));
            if ($urandom_range(3) == 0) busy_or_stray(seq_byte(cut));
            link(other_than(seq_byte(cut)));
        end
        for (int k = 0; k < 4; k++) link(seq_byte(k));
        // Reply step: the content of this word is ignored.
        offer(2'($urandom_range(3)), $urandom(), 8'($urandom_range(255)));
        repeat ($urandom_range(2)) busy_or_stray(HANDSHAKE_REPLY);
        link(HANDSHAKE_REPLY);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, sends with stray and busy words, both
        // handshakes including the wait on other bytes, a match restart,
        // the reply step and a stray before the final echo.
        offer(OP_LINK_WORD, 32'hFFFF_FFFF, 8'h00);
        offer(OP_LINK_WORD, 32'h0000_0000, 8'hFF);
        offer(OP_SEND, 32'h0000_0000, 8'hFF);
        offer(OP_SEND, 32'hFFFF_FFFF, 8'h00);
        link(8'h12);
        offer(OP_LINK_WORD, 32'h0000_0000, 8'h00);
        offer(OP_SEND, 32'h0000_0000, 8'h00);
        offer(OP_INITIATE, 32'h0000_0000, 8'h00);
        offer(OP_LINK_WORD, 32'hFFFF_FFFF, 8'hFF);
        offer(OP_INITIATE, 32'h0000_0000, 8'h00);
        offer(OP_RESPOND, 32'h0000_0000, 8'h00);
        for (int k = 0; k < 4; k++) link(seq_byte(k));
        link(8'h55);
        link(HANDSHAKE_REPLY);
        offer(OP_RESPOND, 32'hFFFF_FFFF, 8'hFF);
        link(8'h02);
        link(8'h05);
        for (int k = 0; k < 4; k++) link(seq_byte(k));
        offer(OP_SEND, $urandom(), 8'hAB);
        link(8'h33);
        link(HANDSHAKE_REPLY);

        // Random: mostly complete exchanges with random content and noise.
        while (n_items < ITEM_TARGET) begin
            if (n_items >= 300) hold_req = 1'b1;
            if (n_items >= 600 && n_items < 640) wait_drained();
            steady = (n_items >= 800 && n_items < 950);
            case ($urandom_range(9))
                0, 1:    repeat (1 + $urandom_range(2))
                             offer(OP_LINK_WORD, $urandom(), 8'($urandom_range(255)));
                2, 3, 4: run_send(8'($urandom_range(255)));
                5, 6:    run_initiator();
                default: run_responder();
            endcase
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end
        else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/eabl_pkg.sv
src/eabl_in_reg.sv
src/eabl_step.sv
src/eabl_out_reg.sv
src/echo_ack_byte_link_endpoint_top.sv
dv/link_endpoint_checker.sv
dv/tb.sv
